// ===== sv/cma_pkg.sv =====
// Package for the covariance matrix accumulator.
// Holds the sequencer state type, register indexes and fixed field widths.
// No dependencies.
`default_nettype none

package cma_pkg;

    // Configuration port layout.
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_DIVISOR = 1'd1;

    // Fixed field widths.
    localparam int unsigned COLS_W = 4;
    localparam int unsigned SCALE_W = 16;
    localparam int unsigned VALUE_W = 48;
    localparam int unsigned IDX_OUT_W = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_READ,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } cma_state_t;

endpackage

`default_nettype wire

// ===== sv/covariance_matrix_accumulator.sv =====
// Uncentered covariance matrix accumulator, top level.
// Depends on cma_pkg; one shared multiplier and a bit-serial divider.
//
// Usage:
//   Samples arrive on the input channel (in_valid/in_ready, sample,
//   last_sample) in row-major order, cols_in_use samples to a row. Each
//   beat is multiplied with itself and with every earlier sample of its row
//   through one shared multiplier, one product per cycle, and the products
//   are added into a 48-bit upper-triangle store of product sums.
//   pos is a sample's column, 0..7; in_ready is low while the
//   multiply-accumulate sequence of that sample runs.
//   A beat with last_sample set closes the data set. The block then emits
//   cols x cols result beats in row-major order (out_valid/out_ready). Each
//   entry is read from the store and divided in a one-bit-per-cycle restoring
//   divider, or, when the effective divisor is zero, the divider is skipped
//   and divide_error is raised with a zero value.
//   When the receiver stalls, the result beat is held in the output
//   registers and the sequencer waits; no input is taken during emission.
//   By the end of the final beat the store, row count and column position
//   are clear and in_ready rises again. Reset clears all control state and
//   marks every sum as zero. Configuration writes take effect at once and
//   are meant to be made while the block is idle.
`default_nettype none

module covariance_matrix_accumulator #(
    parameter int MAX_COLS = 8,
    parameter int MAX_ROWS = 65536,
    parameter int SAMPLE_WIDTH = 16,
    parameter int SUM_WIDTH = 48
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // Configuration write port
    input  wire                                 cfg_write_en,
    input  wire  [cma_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [cma_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Sample channel
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  signed [SAMPLE_WIDTH-1:0]      sample,
    input  wire                                 last_sample,
    // Result channel
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic signed [cma_pkg::VALUE_W-1:0]  moment_value,
    output logic [cma_pkg::IDX_OUT_W-1:0]       out_row,
    output logic [cma_pkg::IDX_OUT_W-1:0]       out_col,
    output logic                                last_entry,
    output logic                                divide_error
);

    import cma_pkg::*;

    localparam int TRI_DEPTH = (MAX_COLS * (MAX_COLS + 1)) / 2;
    localparam int TRI_AW = (TRI_DEPTH > 1) ? $clog2(TRI_DEPTH) : 1;
    localparam int CI_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W = $clog2(MAX_COLS + 1);
    localparam int RC_W = $clog2(MAX_ROWS + 1);
    localparam int DIV_W = (RC_W > SCALE_W) ? RC_W : SCALE_W;
    localparam int PROD_W = 2 * SAMPLE_WIDTH;
    localparam int MAC_W = (PROD_W > SUM_WIDTH) ? PROD_W : SUM_WIDTH;
    localparam int DCNT_W = $clog2(SUM_WIDTH + 1);
    localparam int EXT_W = (SUM_WIDTH > VALUE_W) ? SUM_WIDTH : VALUE_W;

    // Address of upper-triangle entry (lo, hi) with lo <= hi.
    function automatic logic [TRI_AW-1:0] tri_addr(input logic [CI_W-1:0] lo,
                                                   input logic [CI_W-1:0] hi);
        int base;
        base = (int'(lo) * (2 * MAX_COLS + 1 - int'(lo))) >> 1;
        return TRI_AW'(base) + TRI_AW'(hi) - TRI_AW'(lo);
    endfunction

    // Control state
    cma_state_t                 state_reg, state_next;
    logic [COLS_W-1:0]          cols_in_use_reg, cols_in_use_next;
    logic [SCALE_W-1:0]         scale_divisor_reg, scale_divisor_next;
    logic [CI_W-1:0]            column_position_reg, column_position_next;
    logic [RC_W-1:0]            row_count_reg, row_count_next;
    logic [CI_W-1:0]            pos_reg, pos_next;
    logic [CI_W-1:0]            j_reg, j_next;
    logic                       last_reg, last_next;
    logic [CNT_W-1:0]           cols_eff_reg, cols_eff_next;
    logic                       wr_pend_reg, wr_pend_next;
    logic [CI_W-1:0]            r_reg, r_next;
    logic [CI_W-1:0]            c_reg, c_next;
    logic [DCNT_W-1:0]          dcnt_reg, dcnt_next;
    logic                       div_zero_reg, div_zero_next;
    logic                       sum_valid_reg [TRI_DEPTH];
    logic                       rd_hit_reg;

    // Datapath registers
    logic signed [SAMPLE_WIDTH-1:0] x_reg, x_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic [TRI_AW-1:0]          wr_addr_reg, wr_addr_next;
    logic [DIV_W-1:0]           div_reg, div_next;
    logic                       neg_reg, neg_next;
    logic [SUM_WIDTH-1:0]       dvd_reg, dvd_next;
    logic [DIV_W-1:0]           rem_reg, rem_next;
    logic [SUM_WIDTH-1:0]       rd_data_reg;

    // Storage
    logic signed [SAMPLE_WIDTH-1:0] row_buf [MAX_COLS];
    logic [SUM_WIDTH-1:0]       sum_mem [TRI_DEPTH];

    // Combinational helpers
    logic [CNT_W-1:0]           eff_cols;
    logic [CI_W-1:0]            pos_w;
    logic [CNT_W-1:0]           pos_inc;
    logic                       accept;
    logic [TRI_AW-1:0]          mac_addr;
    logic [TRI_AW-1:0]          emit_addr;
    logic [TRI_AW-1:0]          rd_addr;
    logic [CI_W-1:0]            emit_lo, emit_hi;
    logic [SUM_WIDTH-1:0]       sum_rd;
    logic signed [MAC_W-1:0]    prod_ext;
    logic [SUM_WIDTH-1:0]       sum_new;
    logic                       clear_sums;
    logic                       last_ent;
    logic                       c_wrap;
    logic [DIV_W-1:0]           div_sel;
    logic [DIV_W:0]             rem_sh;
    logic [DIV_W+1:0]           trial;
    logic [SUM_WIDTH-1:0]       res_u;
    logic signed [EXT_W-1:0]    res_ext;

    // Column count as used: zero acts as one, large values clamp.
    always_comb
    begin
        if (cols_in_use_reg == '0)
            eff_cols = CNT_W'(1);
        else if (cols_in_use_reg > COLS_W'(MAX_COLS))
            eff_cols = CNT_W'(MAX_COLS);
        else
            eff_cols = CNT_W'(cols_in_use_reg);
    end

    // A stale position past the column count starts a new row.
    assign pos_w = (CNT_W'(column_position_reg) >= eff_cols) ? '0 : column_position_reg;
    assign pos_inc = CNT_W'(pos_w) + CNT_W'(1);

    assign in_ready = (state_reg == ST_IDLE);
    assign accept = in_valid && in_ready;

    assign mac_addr = tri_addr(j_reg, pos_reg);
    assign emit_lo = (r_reg < c_reg) ? r_reg : c_reg;
    assign emit_hi = (r_reg < c_reg) ? c_reg : r_reg;
    assign emit_addr = tri_addr(emit_lo, emit_hi);
    assign rd_addr = (state_reg == ST_MAC) ? mac_addr : emit_addr;

    // Entries not yet written since the last clear read as zero.
    assign sum_rd = rd_hit_reg ? rd_data_reg : '0;
    assign prod_ext = MAC_W'(prod_reg);
    assign sum_new = sum_rd + prod_ext[SUM_WIDTH-1:0];

    assign c_wrap = (CNT_W'(c_reg) + CNT_W'(1) == cols_eff_reg);
    assign last_ent = c_wrap && (CNT_W'(r_reg) + CNT_W'(1) == cols_eff_reg);

    // Effective divisor: zero scale selects rows minus one.
    always_comb
    begin
        if (scale_divisor_reg != '0)
            div_sel = DIV_W'(scale_divisor_reg);
        else if (row_count_reg != '0)
            div_sel = DIV_W'(row_count_reg - RC_W'(1));
        else
            div_sel = '0;
    end

    // One restoring division step.
    assign rem_sh = {rem_reg, dvd_reg[SUM_WIDTH-1]};
    assign trial = {1'b0, rem_sh} - {2'b00, div_reg};

    always_comb
    begin
        state_next = state_reg;
        cols_in_use_next = cols_in_use_reg;
        scale_divisor_next = scale_divisor_reg;
        column_position_next = column_position_reg;
        row_count_next = row_count_reg;
        pos_next = pos_reg;
        j_next = j_reg;
        last_next = last_reg;
        cols_eff_next = cols_eff_reg;
        wr_pend_next = 1'b0;
        r_next = r_reg;
        c_next = c_reg;
        dcnt_next = dcnt_reg;
        div_zero_next = div_zero_reg;
        x_next = x_reg;
        prod_next = prod_reg;
        wr_addr_next = wr_addr_reg;
        div_next = div_reg;
        neg_next = neg_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        clear_sums = 1'b0;

        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_COLS_IN_USE:   cols_in_use_next = cfg_data[COLS_W-1:0];
                REG_SCALE_DIVISOR: scale_divisor_next = cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    x_next = sample;
                    pos_next = pos_w;
                    j_next = '0;
                    last_next = last_sample;
                    cols_eff_next = eff_cols;
                    if (pos_w == '0 && row_count_reg < RC_W'(MAX_ROWS))
                        row_count_next = row_count_reg + RC_W'(1);
                    if (last_sample || pos_inc >= eff_cols)
                        column_position_next = '0;
                    else
                        column_position_next = CI_W'(pos_inc);
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                prod_next = PROD_W'(row_buf[j_reg]) * PROD_W'(x_reg);
                wr_addr_next = mac_addr;
                wr_pend_next = 1'b1;
                j_next = j_reg + CI_W'(1);
                if (j_reg == pos_reg)
                    state_next = last_reg ? ST_DRAIN : ST_IDLE;
            end
            ST_DRAIN:
            begin
                // The final sum write lands in this cycle.
                div_next = div_sel;
                div_zero_next = (div_sel == '0);
                row_count_next = '0;
                r_next = '0;
                c_next = '0;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                neg_next = sum_rd[SUM_WIDTH-1];
                dvd_next = sum_rd[SUM_WIDTH-1] ? (~sum_rd + 1'b1) : sum_rd;
                rem_next = '0;
                dcnt_next = DCNT_W'(SUM_WIDTH);
                state_next = div_zero_reg ? ST_OUT : ST_DIV;
            end
            ST_DIV:
            begin
                if (!trial[DIV_W+1])
                begin
                    rem_next = trial[DIV_W-1:0];
                    dvd_next = {dvd_reg[SUM_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[DIV_W-1:0];
                    dvd_next = {dvd_reg[SUM_WIDTH-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(1))
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (last_ent)
                    begin
                        clear_sums = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (c_wrap)
                        begin
                            c_next = '0;
                            r_next = r_reg + CI_W'(1);
                        end
                        else
                        begin
                            c_next = c_reg + CI_W'(1);
                        end
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cols_in_use_reg <= COLS_W'(MAX_COLS);
            scale_divisor_reg <= '0;
            column_position_reg <= '0;
            row_count_reg <= '0;
            pos_reg <= '0;
            j_reg <= '0;
            last_reg <= 1'b0;
            cols_eff_reg <= CNT_W'(MAX_COLS);
            wr_pend_reg <= 1'b0;
            r_reg <= '0;
            c_reg <= '0;
            dcnt_reg <= '0;
            div_zero_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cols_in_use_reg <= cols_in_use_next;
            scale_divisor_reg <= scale_divisor_next;
            column_position_reg <= column_position_next;
            row_count_reg <= row_count_next;
            pos_reg <= pos_next;
            j_reg <= j_next;
            last_reg <= last_next;
            cols_eff_reg <= cols_eff_next;
            wr_pend_reg <= wr_pend_next;
            r_reg <= r_next;
            c_reg <= c_next;
            dcnt_reg <= dcnt_next;
            div_zero_reg <= div_zero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        prod_reg <= prod_next;
        wr_addr_reg <= wr_addr_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    // Per-entry valid bits stand in for clearing the sum store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TRI_DEPTH; i++)
                sum_valid_reg[i] <= 1'b0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (clear_sums)
            begin
                for (int i = 0; i < TRI_DEPTH; i++)
                    sum_valid_reg[i] <= 1'b0;
            end
            else if (wr_pend_reg)
            begin
                sum_valid_reg[wr_addr_reg] <= 1'b1;
            end
            rd_hit_reg <= sum_valid_reg[rd_addr];
        end
    end

    // Sum store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
            sum_mem[wr_addr_reg] <= sum_new;
        rd_data_reg <= sum_mem[rd_addr];
    end

    // Row buffer holds the samples of the current row.
    always_ff @(posedge clk)
    begin
        if (accept)
            row_buf[pos_w] <= sample;
    end

    // Result beat, held in registers while the receiver stalls.
    assign res_u = neg_reg ? (~dvd_reg + 1'b1) : dvd_reg;
    assign res_ext = EXT_W'($signed(res_u));

    assign out_valid = (state_reg == ST_OUT);
    assign moment_value = div_zero_reg ? '0 : res_ext[VALUE_W-1:0];
    assign out_row = IDX_OUT_W'(r_reg);
    assign out_col = IDX_OUT_W'(c_reg);
    assign last_entry = last_ent;
    assign divide_error = div_zero_reg;

endmodule

`default_nettype wire

// ===== sv/cma_checker.sv =====
// Port-level checker for the covariance matrix accumulator, with its bind.
// Depends on cma_pkg and on the top level's port list.
`default_nettype none

module cma_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input wire                                 clk,
    input wire                                 rst_n,
    input wire                                 in_valid,
    input wire                                 in_ready,
    input wire signed [SAMPLE_WIDTH-1:0]       sample,
    input wire                                 last_sample,
    input wire                                 out_valid,
    input wire                                 out_ready,
    input wire signed [cma_pkg::VALUE_W-1:0]   moment_value,
    input wire [cma_pkg::IDX_OUT_W-1:0]        out_row,
    input wire [cma_pkg::IDX_OUT_W-1:0]        out_col,
    input wire                                 last_entry,
    input wire                                 divide_error
);

    import cma_pkg::*;

    // A stalled result beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(moment_value)
            && $stable(out_row) && $stable(out_col))
    else $error("result beat changed while stalled");

    // Samples are never taken during emission.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
    else $error("input ready while emitting results");

    // A sample that does not close the set yields no result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !last_sample |=> !out_valid)
    else $error("result appeared after a non-final sample");

    // Emission ends with the last entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_entry |=> !out_valid)
    else $error("result beat after the last entry");

    // A zero divisor forces a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_error |-> moment_value == '0)
    else $error("nonzero value with divide error");

endmodule

bind covariance_matrix_accumulator cma_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_cma_checker (.*);

`default_nettype wire

// ===== bench/tb_covariance_matrix_accumulator.sv =====
// Self-checking bench for covariance_matrix_accumulator: directed and random data sets.
// Needs cma_pkg and the block's RTL; every result beat is predicted inside the bench.
`timescale 1ns / 1ps

module tb_covariance_matrix_accumulator;
    import cma_pkg::*;

    localparam int unsigned COLS_MAX = 8;
    localparam int unsigned ROWS_CAP = 65536;
    localparam int unsigned SLOTS = COLS_MAX * (COLS_MAX + 1) / 2;
    // A non-final sample may still be in its multiply-accumulate sequence, and the
    // store is cleared right after the final result beat, so SETTLE_CYCLES of quiet
    // are enough before touching the registers.
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam longint unsigned CYCLE_LIMIT = 3000000;

    // One expected result beat.
    typedef struct {
        logic signed [VALUE_W-1:0]   value;
        logic        [IDX_OUT_W-1:0] row;
        logic        [IDX_OUT_W-1:0] col;
        logic                        last;
        logic                        div_err;
    } moment_entry_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic               in_valid = 1'b0;
    wire                in_ready;
    logic signed [15:0] sample = '0;
    logic               last_sample = 1'b0;

    wire                        out_valid;
    logic                       out_ready = 1'b0;
    wire signed [VALUE_W-1:0]   moment_value;
    wire        [IDX_OUT_W-1:0] out_row;
    wire        [IDX_OUT_W-1:0] out_col;
    wire                        last_entry;
    wire                        divide_error;

    covariance_matrix_accumulator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .last_sample  (last_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .moment_value (moment_value),
        .out_row      (out_row),
        .out_col      (out_col),
        .last_entry   (last_entry),
        .divide_error (divide_error)
    );

    always #5 clk = ~clk;

    // Bench copy of the block's state and registers.
    logic [VALUE_W-1:0]  sums_model [SLOTS];
    logic signed [15:0]  row_samples [COLS_MAX];
    int unsigned         next_col;
    int unsigned         rows_begun;
    logic [COLS_W-1:0]   cols_setting;
    logic [SCALE_W-1:0]  divisor_setting;

    moment_entry_t pending_moments[$];
    int            mismatch_count = 0;
    longint unsigned cycle_count = 0;

    bit          gaps_enabled = 1'b1;
    bit          stalls_enabled = 1'b1;
    int unsigned ready_hold = 0;

    // A column count of zero behaves as one, and anything above eight as eight.
    function automatic int unsigned active_cols();
        if (cols_setting == 0)
            return 1;
        if (cols_setting > COLS_MAX)
            return COLS_MAX;
        return 32'(cols_setting);
    endfunction

    // Position of entry (r,c) in the packed upper triangle; (r,c) and (c,r) share it.
    function automatic int unsigned slot_of(int unsigned r, int unsigned c);
        int unsigned lo;
        int unsigned hi;
        lo = (r < c) ? r : c;
        hi = (r < c) ? c : r;
        return lo * (2 * COLS_MAX - lo + 1) / 2 + (hi - lo);
    endfunction

    // Folds one accepted sample beat into the product sums. A beat that closes the
    // set queues the whole cols x cols matrix and then clears the accumulation.
    function automatic void accumulate_sample(logic signed [15:0] x, logic closes_set);
        int unsigned         cols;
        int unsigned         pos;
        int unsigned         divisor;
        int unsigned         j;
        int unsigned         r;
        int unsigned         c;
        logic signed [31:0]  prod;
        logic signed [VALUE_W-1:0] sum_s;
        longint              total;
        longint              quotient;
        moment_entry_t       e;

        cols = active_cols();
        pos = next_col;
        // A shrunken column count can leave the position past the row end;
        // the beat then opens a fresh row.
        if (pos >= cols)
            pos = 0;
        if (pos == 0 && rows_begun < ROWS_CAP)
            rows_begun++;
        row_samples[pos] = x;
        for (j = 0; j <= pos; j++)
        begin
            prod = 32'(row_samples[j]) * 32'(x);
            sums_model[slot_of(j, pos)] += {{(VALUE_W - 32){prod[31]}}, prod};
        end
        next_col = (pos + 1 >= cols) ? 0 : pos + 1;

        if (!closes_set)
            return;

        // Zero in the scale register means rows minus one, which is zero itself
        // for a single-row set.
        if (divisor_setting != 0)
            divisor = 32'(divisor_setting);
        else
            divisor = (rows_begun > 0) ? rows_begun - 1 : 0;

        for (r = 0; r < cols; r++)
        begin
            for (c = 0; c < cols; c++)
            begin
                sum_s = sums_model[slot_of(r, c)];
                total = longint'(sum_s);
                if (divisor == 0)
                    e.value = '0;
                else
                begin
                    quotient = total / longint'(divisor);
                    e.value = quotient[VALUE_W-1:0];
                end
                e.row = r[IDX_OUT_W-1:0];
                e.col = c[IDX_OUT_W-1:0];
                e.last = (r == cols - 1) && (c == cols - 1);
                e.div_err = (divisor == 0);
                pending_moments.push_back(e);
            end
        end

        foreach (sums_model[i])
            sums_model[i] = '0;
        next_col = 0;
        rows_begun = 0;
    endfunction

    // Receiver: out_ready drops in bursts of random length while stalls are enabled.
    always @(posedge clk)
    begin
        if (ready_hold != 0)
        begin
            ready_hold <= ready_hold - 1;
            out_ready <= 1'b0;
        end
        else if (stalls_enabled && $urandom_range(0, 7) == 0)
        begin
            ready_hold <= $urandom_range(0, 14);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Result checker: every accepted result beat is matched against the oldest
    // expectation. Sampling at the rising edge sees the values from before the edge.
    always @(posedge clk)
    begin
        moment_entry_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_moments.size() == 0)
            begin
                $display("%0t: unexpected result beat: expected none, got (%0d,%0d) value %0d",
                         $time, out_row, out_col, moment_value);
                mismatch_count++;
            end
            else
            begin
                want = pending_moments.pop_front();
                if (moment_value !== want.value || out_row !== want.row ||
                    out_col !== want.col || last_entry !== want.last ||
                    divide_error !== want.div_err)
                begin
                    $display("%0t: mismatch: expected (%0d,%0d) value %0d last %0b err %0b",
                             $time, want.row, want.col, want.value, want.last, want.div_err);
                    $display("%0t:           got (%0d,%0d) value %0d last %0b err %0b",
                             $time, out_row, out_col, moment_value, last_entry, divide_error);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_covariance_matrix_accumulator: errors");
            $finish;
        end
    end

    // Sends one sample beat. It is entered and left at a rising edge; valid stays
    // high after acceptance so a following beat can go out back to back, and any
    // caller that stops sending lowers it through wait_for_results.
    task automatic send_sample(input logic signed [15:0] x, input logic closes_set);
        if (gaps_enabled && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= x;
        last_sample <= closes_set;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        accumulate_sample(x, closes_set);
    endtask

    // Holds the input back until every queued result beat has arrived, then lets
    // any multiply-accumulate still in flight finish.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_moments.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both registers once the block is quiet. Bits above the column field
    // are passed through so that the block's masking is exercised too.
    task automatic write_config(input logic [CFG_DATA_W-1:0] cols_word,
                                input logic [CFG_DATA_W-1:0] scale_word);
        wait_for_results();
        cfg_write_en <= 1'b1;
        cfg_index <= REG_COLS_IN_USE;
        cfg_data <= cols_word;
        @(posedge clk);
        cfg_index <= REG_SCALE_DIVISOR;
        cfg_data <= scale_word;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cols_setting = cols_word[COLS_W-1:0];
        divisor_setting = scale_word[SCALE_W-1:0];
    endtask

    // Random sample with extra weight on the two extremes and on small values.
    function automatic logic signed [15:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'($signed($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // Reset configuration: eight columns and an automatic divisor. A single row
    // gives a divisor of zero, so all 64 entries flag the error with value zero.
    task automatic test_reset_defaults();
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd12345, 1'b0);
        send_sample(-16'sd21846, 1'b0);
        send_sample(16'sd21845, 1'b1);
    endtask

    // A column count of zero behaves as one column; two rows with divisor one.
    task automatic test_zero_columns();
        write_config(16'h0000, 16'h0001);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b1);
    endtask

    // Three columns with junk in the upper data bits, the largest divisor, and a
    // final row cut short after its first element: the missing ones count as zero.
    task automatic test_partial_row();
        write_config(16'hFFF3, 16'hFFFF);
        send_sample(-16'sd32768, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b1);
    endtask

    // Fifteen columns clamp to eight. Five beats in, the count drops to four, so
    // the next beat opens a new row. Mixed signs check truncation toward zero.
    task automatic test_cols_change_mid_row();
        write_config(16'h000F, 16'h0007);
        send_sample(-16'sd7, 1'b0);
        send_sample(16'sd13, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd3, 1'b0);
        write_config(16'h0004, 16'h0007);
        send_sample(16'sd5, 1'b0);
        send_sample(-16'sd9, 1'b1);
    endtask

    // Random data sets. Most are whole rows closed on the last element; some end
    // in a partial row, and some are stray beats without a closing mark that
    // shift the row alignment of the next set.
    task automatic test_random_sets(input int unsigned item_target);
        int unsigned sent;
        int unsigned cols;
        int unsigned length;
        int unsigned k;
        logic [CFG_DATA_W-1:0] cols_word;
        logic [CFG_DATA_W-1:0] scale_word;

        sent = 0;
        while (sent < item_target)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 9))
                    0: cols_word = 16'd0;
                    1: cols_word = 16'd8;
                    2: cols_word = 16'($urandom_range(9, 15));
                    3: cols_word = 16'($urandom_range(5, 7));
                    default: cols_word = 16'($urandom_range(1, 4));
                endcase
                if ($urandom_range(0, 3) == 0)
                    cols_word[CFG_DATA_W-1:COLS_W] = (CFG_DATA_W - COLS_W)'($urandom);
                case ($urandom_range(0, 7))
                    0, 1: scale_word = 16'd0;
                    2: scale_word = 16'd1;
                    3: scale_word = 16'hFFFF;
                    4: scale_word = 16'($urandom);
                    default: scale_word = 16'($urandom_range(2, 9));
                endcase
                write_config(cols_word, scale_word);
            end
            else if ($urandom_range(0, 4) == 0)
                wait_for_results();

            cols = active_cols();
            length = $urandom_range(1, 3) * cols;
            case ($urandom_range(0, 9))
                0: length = $urandom_range(1, length);
                1:
                begin
                    length = $urandom_range(1, cols);
                    for (k = 0; k < length; k++)
                        send_sample(random_sample(), 1'b0);
                    sent += length;
                    continue;
                end
                default: ;
            endcase
            for (k = 0; k < length; k++)
                send_sample(random_sample(), k == length - 1);
            sent += length;
        end
    endtask

    initial
    begin
        cols_setting = COLS_W'(COLS_MAX);
        divisor_setting = '0;
        next_col = 0;
        rows_begun = 0;
        foreach (sums_model[i])
            sums_model[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_columns();
        test_partial_row();
        test_cols_change_mid_row();
        test_random_sets(80);

        // Final stretch runs at full rate on both sides.
        gaps_enabled = 1'b0;
        stalls_enabled = 1'b0;
        test_random_sets(20);

        wait_for_results();
        if (mismatch_count == 0)
            $display("tb_covariance_matrix_accumulator: clean");
        else
            $display("tb_covariance_matrix_accumulator: errors");
        $finish;
    end

endmodule
